FILE: rtl/rlpe_pkg.sv
// ----------------------------------------------------------------------------
// rlpe_pkg
// shared types, constants and the timing table of the led pulse encoder
// ----------------------------------------------------------------------------
`default_nettype none

package rlpe_pkg;

  localparam int PIXEL_BITS  = 24;
  localparam int CNT_W       = 5;
  localparam int TICK_W      = 15;
  localparam int TYPE_W      = 2;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  // register index decoded from paddr[2]
  localparam logic REG_LED_TYPE = 1'b0;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] bits;
    logic                  last_pixel;
  } word_t;

  typedef struct packed {
    logic [TICK_W-1:0] t0h;
    logic [TICK_W-1:0] t0l;
    logic [TICK_W-1:0] t1h;
    logic [TICK_W-1:0] t1l;
    logic [TICK_W-1:0] trs;
  } timing_t;

  function automatic timing_t timing(input logic [TYPE_W-1:0] led_type);
    timing_t t;
    case (led_type)
      2'd0: t = '{t0h: 15'd7, t0l: 15'd16, t1h: 15'd14, t1l: 15'd12, trs: 15'd1000};
      2'd1: t = '{t0h: 15'd7, t0l: 15'd18, t1h: 15'd18, t1l: 15'd7,  trs: 15'd1000};
      2'd2: t = '{t0h: 15'd6, t0l: 15'd18, t1h: 15'd12, t1l: 15'd12, trs: 15'd1600};
      2'd3: t = '{t0h: 15'd7, t0l: 15'd7,  t1h: 15'd16, t1l: 15'd7,  trs: 15'd6000};
      default: t = '{t0h: 15'd7, t0l: 15'd16, t1h: 15'd14, t1l: 15'd12, trs: 15'd1000};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rlpe_front.sv
// ----------------------------------------------------------------------------
// rlpe_front
// accepts pixels, packs them green-red-blue and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module rlpe_front #(
  parameter int QueueDepth = rlpe_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [7:0]           red,
  input  wire logic [7:0]           green,
  input  wire logic [7:0]           blue,
  input  wire logic                 frame_last_pixel,
  output logic                      q_valid,
  output rlpe_pkg::word_t           q_word,
  input  wire logic                 q_take
);

  localparam int PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CNT_W = $clog2(QueueDepth + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QueueDepth - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QueueDepth);

  rlpe_pkg::word_t  mem [QueueDepth];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_word  = mem[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= '{bits: {green, red, blue}, last_pixel: frame_last_pixel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rlpe_back.sv
// ----------------------------------------------------------------------------
// rlpe_back
// shifts a queued pixel out msb first into an output register, one pulse
// pair per cycle while that register is empty or being popped
// ----------------------------------------------------------------------------
`default_nettype none

module rlpe_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [rlpe_pkg::TYPE_W-1:0]    led_type,
  input  wire logic                           q_valid,
  input  wire rlpe_pkg::word_t                q_word,
  output logic                                q_take,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [rlpe_pkg::TICK_W-1:0]         high_ticks,
  output logic [rlpe_pkg::TICK_W-1:0]         low_ticks,
  output logic                                pixel_done,
  output logic                                frame_end
);

  localparam logic [rlpe_pkg::CNT_W-1:0] FULL_CNT = rlpe_pkg::CNT_W'(rlpe_pkg::PIXEL_BITS);

  logic [rlpe_pkg::PIXEL_BITS-1:0] bit_shifter;
  logic [rlpe_pkg::CNT_W-1:0]      bits_left;
  logic                            end_pending;
  logic                            out_valid;
  logic                            adv;
  logic                            busy;
  logic                            gen;
  logic                            last;
  logic                            cur_bit;
  rlpe_pkg::timing_t               t;
  logic [rlpe_pkg::TICK_W-1:0]     hi_next;
  logic [rlpe_pkg::TICK_W-1:0]     lo_next;

  assign empty   = !out_valid;
  assign adv     = !out_valid || pop;
  assign busy    = (bits_left != '0);
  assign gen     = busy && adv;
  assign last    = (bits_left == rlpe_pkg::CNT_W'(1));
  assign q_take  = q_valid && (!busy || (last && adv));
  assign cur_bit = bit_shifter[rlpe_pkg::PIXEL_BITS-1];
  assign t       = rlpe_pkg::timing(led_type);

  always_comb begin
    hi_next = cur_bit ? t.t1h : t.t0h;
    if (last && end_pending) begin
      lo_next = t.trs;
    end else begin
      lo_next = cur_bit ? t.t1l : t.t0l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shifter <= '0;
      bits_left   <= '0;
      end_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (q_take) begin
        bit_shifter <= q_word.bits;
        bits_left   <= FULL_CNT;
        end_pending <= q_word.last_pixel;
      end else if (gen) begin
        bit_shifter <= {bit_shifter[rlpe_pkg::PIXEL_BITS-2:0], 1'b0};
        bits_left   <= bits_left - 1'b1;
      end
      if (gen) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      high_ticks <= hi_next;
      low_ticks  <= lo_next;
      pixel_done <= last;
      frame_end  <= last && end_pending;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rgb_led_pulse_encoder_unit.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder_unit
// turns rgb pixels into pulse pair timings for single-wire addressable leds
//
// pixel words enter through push/full; each is reordered green, red, blue
// and queued. the back end sends its 24 bits msb first, one pulse pair word
// per cycle while pop keeps up, through empty/pop. a word carries the high
// and low time in 50 ns ticks; pixel_done marks the 24th word of a pixel and
// frame_end the word whose low time is stretched to the reset time of the
// led type. the front queue holds two pixels so input and output stall
// independently. a pixel pushed into an idle block passes the queue and the
// shifter before its first word reaches the output register.
// when pop is held low the output register holds, the shifter stops, and
// full rises once the queue has two pixels waiting.
// reset empties the queue and output register and sets led_type to 0.
// led_type lies at byte address 0 of the apb port and must be written only
// when the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_pulse_encoder_unit #(
  parameter int QueueDepth = rlpe_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [7:0]                     red,
  input  wire logic [7:0]                     green,
  input  wire logic [7:0]                     blue,
  input  wire logic                           frame_last_pixel,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [rlpe_pkg::TICK_W-1:0]         high_ticks,
  output logic [rlpe_pkg::TICK_W-1:0]         low_ticks,
  output logic                                pixel_done,
  output logic                                frame_end,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rlpe_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [rlpe_pkg::DATA_W-1:0]    pwdata,
  output logic [rlpe_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  logic [rlpe_pkg::TYPE_W-1:0] led_type;
  logic                        q_valid;
  rlpe_pkg::word_t             q_word;
  logic                        q_take;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == rlpe_pkg::REG_LED_TYPE);
  assign prdata  = reg_sel ? rlpe_pkg::DATA_W'(led_type) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_type <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      led_type <= pwdata[rlpe_pkg::TYPE_W-1:0];
    end
  end

  rlpe_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .frame_last_pixel(frame_last_pixel),
    .q_valid         (q_valid),
    .q_word          (q_word),
    .q_take          (q_take)
  );

  rlpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .led_type  (led_type),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_take    (q_take),
    .empty     (empty),
    .pop       (pop),
    .high_ticks(high_ticks),
    .low_ticks (low_ticks),
    .pixel_done(pixel_done),
    .frame_end (frame_end)
  );

  a_reset_empty : assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  a_push_queued : assert property (@(posedge clk) disable iff (rst)
    push && !full |=> q_valid)
    else $error("accepted pixel missing from queue");

  a_end_on_done : assert property (@(posedge clk) disable iff (rst)
    !empty && frame_end |-> pixel_done)
    else $error("frame end away from pixel end");

  a_end_reset_time : assert property (@(posedge clk) disable iff (rst)
    !empty && frame_end |-> low_ticks == rlpe_pkg::timing(led_type).trs)
    else $error("frame end without reset low time");

endmodule

`default_nettype wire

FILE: dv/rgb_led_pulse_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder_unit_tb
// self-checking bench for the rgb led pulse encoder
//
// pixels go in through push/full and pulse pair words come out through
// empty/pop. an in-bench model reorders each pixel to green, red, blue and
// expands its 24 bits into expected words using the timing set of the current
// led_type; every popped word is checked field by field against the oldest
// expectation. led_type is written over apb only while the block is idle.
// covers register access, directed extreme pixels, random frames under
// changing idle rates, and a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_pulse_encoder_unit_tb;

  localparam int PIXELS_PER_PHASE = 60;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = 8;
  localparam int QUIET_LIMIT      = 3000;

  localparam logic [rlpe_pkg::ADDR_W-1:0] LED_TYPE_ADDR = rlpe_pkg::ADDR_W'(0);
  localparam logic [rlpe_pkg::ADDR_W-1:0] UNUSED_ADDR   = rlpe_pkg::ADDR_W'(4);

  typedef enum logic [rlpe_pkg::TYPE_W-1:0] {
    TIMING_SET_0,
    TIMING_SET_1,
    TIMING_SET_2,
    TIMING_SET_3
  } timing_set_e;

  typedef struct packed {
    logic [rlpe_pkg::TICK_W-1:0] zero_hi;
    logic [rlpe_pkg::TICK_W-1:0] zero_lo;
    logic [rlpe_pkg::TICK_W-1:0] one_hi;
    logic [rlpe_pkg::TICK_W-1:0] one_lo;
    logic [rlpe_pkg::TICK_W-1:0] reset_lo;
  } tick_set_t;

  typedef struct packed {
    logic [rlpe_pkg::TICK_W-1:0] hi;
    logic [rlpe_pkg::TICK_W-1:0] lo;
    logic                        done;
    logic                        fend;
  } pulse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [7:0] red = 8'd0;
  logic [7:0] green = 8'd0;
  logic [7:0] blue = 8'd0;
  logic frame_last_pixel = 1'b0;
  logic pop = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rlpe_pkg::ADDR_W-1:0] paddr = '0;
  logic [rlpe_pkg::DATA_W-1:0] pwdata = '0;

  logic full;
  logic empty;
  logic [rlpe_pkg::TICK_W-1:0] high_ticks;
  logic [rlpe_pkg::TICK_W-1:0] low_ticks;
  logic pixel_done;
  logic frame_end;
  logic [rlpe_pkg::DATA_W-1:0] prdata;
  logic pready;

  pulse_t expected_pulses[$];
  pulse_t want;
  logic [rlpe_pkg::TYPE_W-1:0] led_type_now = '0;
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;
  bit running = 1'b0;

  rgb_led_pulse_encoder_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .red(red),
    .green(green),
    .blue(blue),
    .frame_last_pixel(frame_last_pixel),
    .empty(empty),
    .pop(pop),
    .high_ticks(high_ticks),
    .low_ticks(low_ticks),
    .pixel_done(pixel_done),
    .frame_end(frame_end),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic tick_set_t ticks_for(input logic [rlpe_pkg::TYPE_W-1:0] set);
    tick_set_t t;
    case (set)
      TIMING_SET_0: t = '{zero_hi: 15'd7, zero_lo: 15'd16, one_hi: 15'd14,
                          one_lo: 15'd12, reset_lo: 15'd1000};
      TIMING_SET_1: t = '{zero_hi: 15'd7, zero_lo: 15'd18, one_hi: 15'd18,
                          one_lo: 15'd7, reset_lo: 15'd1000};
      TIMING_SET_2: t = '{zero_hi: 15'd6, zero_lo: 15'd18, one_hi: 15'd12,
                          one_lo: 15'd12, reset_lo: 15'd1600};
      default:      t = '{zero_hi: 15'd7, zero_lo: 15'd7, one_hi: 15'd16,
                          one_lo: 15'd7, reset_lo: 15'd6000};
    endcase
    return t;
  endfunction

  // expand one pixel into its 24 pulse pair words
  task automatic encode_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic last);
    tick_set_t t;
    logic [rlpe_pkg::PIXEL_BITS-1:0] stream;
    pulse_t p;
    t = ticks_for(led_type_now);
    stream = {g, r, b};
    for (int i = 0; i < rlpe_pkg::PIXEL_BITS; i++) begin
      p.hi = stream[rlpe_pkg::PIXEL_BITS-1-i] ? t.one_hi : t.zero_hi;
      p.lo = stream[rlpe_pkg::PIXEL_BITS-1-i] ? t.one_lo : t.zero_lo;
      p.done = (i == rlpe_pkg::PIXEL_BITS - 1);
      p.fend = p.done & last;
      if (p.fend) p.lo = t.reset_lo;
      expected_pulses.push_back(p);
    end
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
    logic was_full;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    frame_last_pixel <= last;
    do begin
      @(negedge clk);
      was_full = full;
      @(posedge clk);
    end while (was_full);
    encode_pixel(r, g, b, last);
  endtask

  task automatic send_random_frames(input int count);
    int frame_len;
    int pos;
    logic last;
    frame_len = $urandom_range(1, 6);
    pos = 0;
    for (int n = 0; n < count; n++) begin
      last = (pos == frame_len - 1);
      // occasional misplaced end marker
      if ($urandom_range(9) == 0) last = 1'($urandom_range(1));
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), last);
      pos++;
      if (pos == frame_len) begin
        pos = 0;
        frame_len = $urandom_range(1, 6);
      end
    end
  endtask

  task automatic drain;
    push <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [rlpe_pkg::ADDR_W-1:0] addr,
                           input logic [rlpe_pkg::DATA_W-1:0] data);
    logic ready;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    if (addr[2] == rlpe_pkg::REG_LED_TYPE) led_type_now = data[rlpe_pkg::TYPE_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_check_led_type;
    logic ready;
    logic [rlpe_pkg::DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LED_TYPE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      got = prdata;
      @(posedge clk);
    end while (!ready);
    if (got !== rlpe_pkg::DATA_W'(led_type_now)) begin
      errors++;
      $display("%0t: led_type read expected %0d actual %0d", $time, led_type_now, got);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_registers;
    apb_check_led_type();
    apb_write(LED_TYPE_ADDR, rlpe_pkg::DATA_W'(TIMING_SET_2));
    apb_check_led_type();
    // address past the register list, must not touch led_type
    apb_write(UNUSED_ADDR, rlpe_pkg::DATA_W'(TIMING_SET_1));
    apb_check_led_type();
    // upper bits of the write data are dropped
    apb_write(LED_TYPE_ADDR, 32'hFFFF_FFFD);
    apb_check_led_type();
  endtask

  task automatic test_directed;
    for (int s = 0; s < 4; s++) begin
      apb_write(LED_TYPE_ADDR, rlpe_pkg::DATA_W'(s));
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_pixel(8'h0F, 8'hA5, 8'h5A, 1'b0);
      send_pixel(8'h80, 8'h01, 8'hFE, 1'b1);
      drain();
    end
  endtask

  task automatic test_random;
    tx_idle_pct = 16;
    rx_idle_pct = 69;
    apb_write(LED_TYPE_ADDR, rlpe_pkg::DATA_W'(TIMING_SET_3));
    send_random_frames(PIXELS_PER_PHASE);
    drain();
    tx_idle_pct = 69;
    rx_idle_pct = 16;
    apb_write(LED_TYPE_ADDR, rlpe_pkg::DATA_W'(TIMING_SET_0));
    send_random_frames(PIXELS_PER_PHASE);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apb_write(LED_TYPE_ADDR, rlpe_pkg::DATA_W'($urandom_range(3)));
    send_random_frames(PIXELS_PER_PHASE);
    drain();
  endtask

  task automatic test_backpressure;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apb_write(LED_TYPE_ADDR, rlpe_pkg::DATA_W'(TIMING_SET_1));
    hold_asks++;
    send_random_frames(10);
    drain();
  endtask

  // receiver side
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [rlpe_pkg::TICK_W-1:0] exp_v,
                             input logic [rlpe_pkg::TICK_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // outputs are stable at the falling edge; a word seen here is taken at the next rise
  always @(negedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_pulses.size() == 0) begin
        errors++;
        $display("%0t: unexpected word expected none actual hi %0d lo %0d done %0b end %0b",
                 $time, high_ticks, low_ticks, pixel_done, frame_end);
      end else begin
        want = expected_pulses.pop_front();
        check_field("high_ticks", want.hi, high_ticks);
        check_field("low_ticks", want.lo, low_ticks);
        check_field("pixel_done", rlpe_pkg::TICK_W'(want.done),
                    rlpe_pkg::TICK_W'(pixel_done));
        check_field("frame_end", rlpe_pkg::TICK_W'(want.fend),
                    rlpe_pkg::TICK_W'(frame_end));
      end
    end
  end

  always @(negedge clk) begin
    if (running) begin
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    tx_idle_pct = 16;
    rx_idle_pct = 69;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    running = 1'b1;
    test_registers();
    test_directed();
    test_random();
    test_backpressure();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
